>>> hdl/spc_pkg.sv
package spc_pkg;

	localparam int DEPTH_DEFAULT = 256;
	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		VERDICT_NOT_PERM = 2'd0,
		VERDICT_PERM     = 2'd1,
		VERDICT_OVERFLOW = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_EVAL,
		ST_EMIT
	} spc_state_t;

	// Finished verdict offered by the check controller to the result register.
	typedef struct packed {
		logic     valid;
		verdict_t verdict;
	} spc_verdict_msg_t;

endpackage

>>> hdl/spc_if.sv
interface spc_item_if
	import spc_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] source_value;
	logic signed [VALUE_W-1:0] target_value;
	logic                      last;

	modport source (output valid, output source_value, output target_value, output last,
		input ready);
	modport sink (input valid, input source_value, input target_value, input last,
		output ready);
endinterface

interface spc_result_if
	import spc_pkg::*;
	();
	logic     valid;
	logic     ready;
	verdict_t verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface

>>> hdl/spc_pair_store.sv
module spc_pair_store
	import spc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [VALUE_W-1:0] wr_source,
	input  logic [VALUE_W-1:0] wr_target,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_source_addr,
	input  logic [AW-1:0]      rd_target_addr,
	output logic [VALUE_W-1:0] rd_source,
	output logic [VALUE_W-1:0] rd_target
);

	// One entry holds a source element in the low half and its target in the high half.
	logic [2*VALUE_W-1:0] mem [DEPTH];
	logic [2*VALUE_W-1:0] src_word_q;
	logic [2*VALUE_W-1:0] tgt_word_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_target, wr_source};
		end
		if (rd_en) begin
			src_word_q <= mem[rd_source_addr];
			tgt_word_q <= mem[rd_target_addr];
		end
	end

	assign rd_source = src_word_q[VALUE_W-1:0];
	assign rd_target = tgt_word_q[2*VALUE_W-1:VALUE_W];

endmodule

>>> hdl/spc_work_stack.sv
module spc_work_stack
	import spc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [VALUE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/spc_check_ctrl.sv
module spc_check_ctrl
	import spc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	// item side
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	// result side
	input  logic               out_free,
	output spc_verdict_msg_t   msg,
	// pair store
	output logic               pair_we,
	output logic [AW-1:0]      pair_wr_addr,
	output logic               pair_re,
	output logic [AW-1:0]      pair_src_addr,
	output logic [AW-1:0]      pair_tgt_addr,
	input  logic [VALUE_W-1:0] src_rd,
	input  logic [VALUE_W-1:0] want_rd,
	// work stack
	output logic               stk_we,
	output logic [AW-1:0]      stk_wr_addr,
	output logic [VALUE_W-1:0] stk_wr_data,
	output logic               stk_re,
	output logic [AW-1:0]      stk_rd_addr,
	input  logic [VALUE_W-1:0] top_rd
);

	localparam logic [CW-1:0] FULL = CW'(DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	spc_state_t    state_q, state_d;
	logic [CW-1:0] load_cnt_q;
	logic [CW-1:0] src_idx_q;
	logic [CW-1:0] tgt_idx_q;
	logic [CW-1:0] height_q;
	logic          ovf_q;
	verdict_t      verdict_q;

	logic          accept;
	logic          full;
	logic [CW-1:0] top_idx;
	logic src_left, tgt_left, have_top;
	logic match_src, match_top;
	logic adv_src, adv_tgt, push, pop;
	logic step_done, step_pass;

	assign accept  = in_valid && in_ready;
	assign full    = (load_cnt_q == FULL);
	assign top_idx = height_q - ONE;

	// One step of the greedy walk, decided on the data read in the previous cycle.
	always_comb begin
		src_left  = (src_idx_q < load_cnt_q);
		tgt_left  = (tgt_idx_q < load_cnt_q);
		have_top  = (height_q != '0);
		match_src = (src_rd == want_rd);
		match_top = have_top && (top_rd == want_rd);
		adv_src   = 1'b0;
		adv_tgt   = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		step_done = 1'b0;
		step_pass = 1'b0;
		if (src_left) begin
			if (!tgt_left) begin
				step_done = 1'b1;
			end else if (match_src) begin
				adv_src = 1'b1;
				adv_tgt = 1'b1;
			end else if (match_top) begin
				pop     = 1'b1;
				adv_tgt = 1'b1;
			end else begin
				push    = 1'b1;
				adv_src = 1'b1;
			end
		end else if (have_top) begin
			if (!tgt_left || !match_top) begin
				step_done = 1'b1;
			end else begin
				pop     = 1'b1;
				adv_tgt = 1'b1;
			end
		end else begin
			step_done = 1'b1;
			step_pass = 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && in_last) begin
					state_d = (ovf_q || full) ? ST_EMIT : ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: state_d = step_done ? ST_EMIT : ST_READ;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready      = (state_q == ST_LOAD);
		pair_we       = accept && !full;
		pair_wr_addr  = load_cnt_q[AW-1:0];
		pair_re       = (state_q == ST_READ);
		pair_src_addr = src_idx_q[AW-1:0];
		pair_tgt_addr = tgt_idx_q[AW-1:0];
		stk_we        = (state_q == ST_EVAL) && push;
		stk_wr_addr   = height_q[AW-1:0];
		stk_wr_data   = src_rd;
		stk_re        = (state_q == ST_READ);
		stk_rd_addr   = top_idx[AW-1:0];
		msg.valid     = (state_q == ST_EMIT);
		msg.verdict   = verdict_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			src_idx_q  <= '0;
			tgt_idx_q  <= '0;
			height_q   <= '0;
			ovf_q      <= 1'b0;
			verdict_q  <= VERDICT_NOT_PERM;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							load_cnt_q <= load_cnt_q + ONE;
						end
						if (in_last && (ovf_q || full)) begin
							verdict_q <= VERDICT_OVERFLOW;
						end
					end
				end
				ST_EVAL: begin
					if (adv_src) begin
						src_idx_q <= src_idx_q + ONE;
					end
					if (adv_tgt) begin
						tgt_idx_q <= tgt_idx_q + ONE;
					end
					if (push) begin
						height_q <= height_q + ONE;
					end else if (pop) begin
						height_q <= height_q - ONE;
					end
					if (step_done) begin
						verdict_q <= step_pass ? VERDICT_PERM : VERDICT_NOT_PERM;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						load_cnt_q <= '0;
						src_idx_q  <= '0;
						tgt_idx_q  <= '0;
						height_q   <= '0;
						ovf_q      <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Every element consumed from the source is either on the stack or matched a target.
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, tgt_idx_q} + {1'b0, height_q}) == {1'b0, src_idx_q})
		else $error("stack height and indices out of balance");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> (height_q < FULL))
		else $error("push onto a full work stack");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (src_idx_q == '0 && tgt_idx_q == '0 && height_q == '0))
		else $error("walk indices not cleared while loading");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(load_cnt_q <= FULL) && (src_idx_q <= load_cnt_q))
		else $error("count beyond store depth");

endmodule

>>> hdl/stack_permutation_checker_unit.sv
// Stack permutation checker.
//
// pair: one item carries the next element of the source sequence and the next
// element of the candidate sequence; last marks the final pair. Both sequences
// are written to the pair store at one item per cycle while loading.
// result: one item per sequence, verdict 1 when the candidate is reachable from
// the source through one stack, 0 when not, 2 when more than DEPTH pairs came.
//
// After the last item the walk runs greedy steps, each a memory read, then a
// compare and update; a sequence of n pairs needs between n and 2n steps plus
// one closing step. On overflow the controller goes straight from loading to
// emitting the verdict, with no walk. The pair store and work stack read ports,
// one access per step, set the pace of the walk.
//
// The verdict sits in an output register: while it waits for result.ready the
// block already takes pairs of the next sequence. A second verdict waits in the
// controller until the register frees up, and no pair is taken meanwhile.
// Reset clears all counters and the state; the stores need no clearing since
// only entries written for the current sequence are read.
module stack_permutation_checker_unit
	import spc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	spc_item_if.sink     pair,
	spc_result_if.source result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic               pair_we;
	logic [AW-1:0]      pair_wr_addr;
	logic               pair_re;
	logic [AW-1:0]      pair_src_addr;
	logic [AW-1:0]      pair_tgt_addr;
	logic [VALUE_W-1:0] src_rd;
	logic [VALUE_W-1:0] want_rd;
	logic               stk_we;
	logic [AW-1:0]      stk_wr_addr;
	logic [VALUE_W-1:0] stk_wr_data;
	logic               stk_re;
	logic [AW-1:0]      stk_rd_addr;
	logic [VALUE_W-1:0] top_rd;

	spc_verdict_msg_t msg;
	logic             out_free;
	logic             res_valid_q;
	verdict_t         res_verdict_q;

	// Source and target elements live side by side; the walk reads both each step.
	spc_pair_store #(.DEPTH(DEPTH), .AW(AW)) u_pair_store (
		.clk           (clk),
		.wr_en         (pair_we),
		.wr_addr       (pair_wr_addr),
		.wr_source     (pair.source_value),
		.wr_target     (pair.target_value),
		.rd_en         (pair_re),
		.rd_source_addr(pair_src_addr),
		.rd_target_addr(pair_tgt_addr),
		.rd_source     (src_rd),
		.rd_target     (want_rd)
	);

	// The auxiliary stack; its top is read in the cycle before the compare.
	spc_work_stack #(.DEPTH(DEPTH), .AW(AW)) u_work_stack (
		.clk    (clk),
		.wr_en  (stk_we),
		.wr_addr(stk_wr_addr),
		.wr_data(stk_wr_data),
		.rd_en  (stk_re),
		.rd_addr(stk_rd_addr),
		.rd_data(top_rd)
	);

	spc_check_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_check_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pair.valid),
		.in_last      (pair.last),
		.in_ready     (pair.ready),
		.out_free     (out_free),
		.msg          (msg),
		.pair_we      (pair_we),
		.pair_wr_addr (pair_wr_addr),
		.pair_re      (pair_re),
		.pair_src_addr(pair_src_addr),
		.pair_tgt_addr(pair_tgt_addr),
		.src_rd       (src_rd),
		.want_rd      (want_rd),
		.stk_we       (stk_we),
		.stk_wr_addr  (stk_wr_addr),
		.stk_wr_data  (stk_wr_data),
		.stk_re       (stk_re),
		.stk_rd_addr  (stk_rd_addr),
		.top_rd       (top_rd)
	);

	// Free when empty or being emptied this cycle.
	assign out_free = !res_valid_q || result.ready;

	// Result register: load a finished verdict, hold it while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && msg.valid) begin
			res_verdict_q <= msg.verdict;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.verdict = res_verdict_q;

	// A verdict handed over must show on the result port in the next cycle.
	a_handover: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && out_free) |=> (res_valid_q && res_verdict_q == $past(msg.verdict)))
		else $error("verdict lost on handover");

	// While a stalled result waits, the register must not be overwritten.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> (res_valid_q && $stable(res_verdict_q)))
		else $error("stalled verdict changed");

	// No pair is taken while a verdict waits in the controller.
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg.valid |-> !pair.ready)
		else $error("pair accepted with a verdict pending");

endmodule

>>> tb/sv/tb_stack_permutation_checker_unit.sv
`timescale 1ns / 1ps

module tb_stack_permutation_checker_unit;
	import spc_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	// Longest legal quiet stretch is a full-depth check or
	// the long receiver hold-off; allow several times that.
	localparam int QUIET_LIMIT = 10000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 64;
	localparam int GEN_MAX = DEPTH + 8;

	// Entries of the sender's queue: real pairs plus a few control marks that
	// steer the sender and the receiver when they reach the head.
	typedef enum {
		KIND_PAIR,
		KIND_DRAIN,
		KIND_RX_HOLD,
		KIND_CALM
	} entry_kind_t;

	typedef enum {
		SHAPE_STACK,
		SHAPE_REVERSED,
		SHAPE_SWAPPED,
		SHAPE_SHUFFLED,
		SHAPE_NOISE
	} seq_shape_t;

	typedef struct {
		entry_kind_t kind;
		logic [31:0] src;
		logic [31:0] tgt;
		logic        last;
	} pair_entry_t;

	logic clk = 1'b0;
	logic arst_n;

	spc_item_if   pair_if ();
	spc_result_if result_if ();

	stack_permutation_checker_unit #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pair  (pair_if),
		.result(result_if)
	);

	always #10 clk = ~clk;

	// Stimulus and expectations
	pair_entry_t pending_pairs[$];
	verdict_t    pending_verdicts[$];
	int          mismatches = 0;
	int          queued_pairs = 0;

	// Flags for the negedge drivers: the handshake seen at the last rising edge, and the sender's marks.
	bit pair_taken = 1'b0;
	bit calm = 1'b0;
	bit rx_hold_req = 1'b0;

	// Private copy of the block's sequence store and counters.
	logic [31:0] src_copy [0:DEPTH-1];
	logic [31:0] tgt_copy [0:DEPTH-1];
	logic [31:0] stack_copy [0:DEPTH-1];
	int          loaded_pairs = 0;
	bit          too_many = 1'b0;

	// Scratch arrays for building one sequence.
	logic [31:0] gen_src [0:GEN_MAX-1];
	logic [31:0] gen_tgt [0:GEN_MAX-1];

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Greedy one-stack walk over the stored pairs: match directly, pop a
	// matching top, or push. Then drain the stack; every pop must match.
	function automatic bit reachable_by_stack(input int n);
		int si;
		int ti;
		int h;
		si = 0;
		ti = 0;
		h = 0;
		while (si < n) begin
			if (ti >= n)
				return 1'b0;
			if (src_copy[si] == tgt_copy[ti]) begin
				si++;
				ti++;
			end else if (h > 0 && stack_copy[h-1] == tgt_copy[ti]) begin
				h--;
				ti++;
			end else begin
				if (h >= DEPTH)
					return 1'b0;
				stack_copy[h] = src_copy[si];
				h++;
				si++;
			end
		end
		while (h > 0) begin
			if (ti >= n || stack_copy[h-1] != tgt_copy[ti])
				return 1'b0;
			h--;
			ti++;
		end
		return 1'b1;
	endfunction

	// Store one accepted pair; on the last one work out the verdict and clear.
	task automatic absorb_pair(input logic [31:0] src, input logic [31:0] tgt,
		input logic last);
		if (loaded_pairs < DEPTH) begin
			src_copy[loaded_pairs] = src;
			tgt_copy[loaded_pairs] = tgt;
			loaded_pairs++;
		end else begin
			too_many = 1'b1;
		end
		if (last) begin
			if (too_many)
				pending_verdicts.push_back(VERDICT_OVERFLOW);
			else if (reachable_by_stack(loaded_pairs))
				pending_verdicts.push_back(VERDICT_PERM);
			else
				pending_verdicts.push_back(VERDICT_NOT_PERM);
			loaded_pairs = 0;
			too_many = 1'b0;
		end
	endtask

	task automatic queue_pair(input logic [31:0] src, input logic [31:0] tgt,
		input logic last);
		pair_entry_t e;
		e.kind = KIND_PAIR;
		e.src = src;
		e.tgt = tgt;
		e.last = last;
		pending_pairs.push_back(e);
		queued_pairs++;
	endtask

	task automatic queue_mark(input entry_kind_t kind);
		pair_entry_t e;
		e.kind = kind;
		e.src = '0;
		e.tgt = '0;
		e.last = 1'b0;
		pending_pairs.push_back(e);
	endtask

	// Pools: a tiny range for many duplicates, the corner patterns, or anything.
	function automatic logic [31:0] pick_value(input int pool);
		case (pool)
			0: return 32'($urandom_range(0, 3));
			1: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					3: return 32'h0000_0000;
					default: return 32'h0000_0001;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_sequence(input int n, input seq_shape_t shape);
		logic [31:0] stk[$];
		logic [31:0] tmp;
		int pool;
		int i;
		int o;
		int a;
		int b;
		pool = $urandom_range(0, 3);
		for (i = 0; i < n; i++)
			gen_src[i] = pick_value(pool);
		case (shape)
			SHAPE_REVERSED: begin
				for (i = 0; i < n; i++)
					gen_tgt[i] = gen_src[n-1-i];
			end
			SHAPE_SHUFFLED: begin
				for (i = 0; i < n; i++)
					gen_tgt[i] = gen_src[i];
				for (i = n - 1; i > 0; i--) begin
					a = $urandom_range(0, i);
					tmp = gen_tgt[i];
					gen_tgt[i] = gen_tgt[a];
					gen_tgt[a] = tmp;
				end
			end
			SHAPE_NOISE: begin
				for (i = 0; i < n; i++)
					gen_tgt[i] = pick_value(pool);
			end
			default: begin
				// Random push/pop schedule: always a reachable order.
				i = 0;
				o = 0;
				while (o < n) begin
					if (i < n && (stk.size() == 0 || $urandom_range(0, 1))) begin
						stk.push_back(gen_src[i]);
						i++;
					end else begin
						gen_tgt[o] = stk.pop_back();
						o++;
					end
				end
				if (shape == SHAPE_SWAPPED) begin
					a = $urandom_range(0, n - 1);
					b = $urandom_range(0, n - 1);
					tmp = gen_tgt[a];
					gen_tgt[a] = gen_tgt[b];
					gen_tgt[b] = tmp;
				end
			end
		endcase
		for (i = 0; i < n; i++)
			queue_pair(gen_src[i], gen_tgt[i], i == n - 1);
	endtask

	function automatic seq_shape_t pick_shape();
		int r;
		r = $urandom_range(0, 19);
		if (r <= 10)
			return SHAPE_STACK;
		else if (r <= 13)
			return SHAPE_SWAPPED;
		else if (r <= 16)
			return SHAPE_SHUFFLED;
		else if (r <= 18)
			return SHAPE_NOISE;
		return SHAPE_REVERSED;
	endfunction

	task automatic queue_random_until(input int pair_goal);
		int n;
		while (queued_pairs < pair_goal) begin
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(13, 40);
			else
				n = $urandom_range(1, 12);
			queue_sequence(n, pick_shape());
		end
	endtask

	// Sender: advance on the falling edge. Hold the item while it is not taken;
	// otherwise work through control marks at the head, idle in bursts, or
	// present the next pair. valid gets at most one assignment per edge.
	int tx_gap = 0;

	always @(negedge clk) begin
		pair_entry_t e;
		bit picked;
		bit nxt_valid;
		if (!arst_n) begin
			pair_if.valid <= 1'b0;
		end else if (!pair_if.valid || pair_taken) begin
			nxt_valid = 1'b0;
			picked = 1'b0;
			while (!picked && pending_pairs.size() != 0) begin
				e = pending_pairs[0];
				case (e.kind)
					KIND_DRAIN: begin
						// Pause until every verdict owed has come back.
						if (pending_verdicts.size() == 0)
							void'(pending_pairs.pop_front());
						else
							picked = 1'b1;
					end
					KIND_RX_HOLD: begin
						rx_hold_req = 1'b1;
						void'(pending_pairs.pop_front());
					end
					KIND_CALM: begin
						calm = 1'b1;
						void'(pending_pairs.pop_front());
					end
					default: begin
						picked = 1'b1;
						if (tx_gap > 0) begin
							tx_gap--;
						end else if (!calm && $urandom_range(0, 7) == 0) begin
							tx_gap = $urandom_range(0, 8);
						end else begin
							pair_if.source_value <= e.src;
							pair_if.target_value <= e.tgt;
							pair_if.last <= e.last;
							nxt_valid = 1'b1;
							void'(pending_pairs.pop_front());
						end
					end
				endcase
			end
			pair_if.valid <= nxt_valid;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off so the verdict
	// register and the controller both fill and the block stalls its input.
	int rx_gap = 0;
	int rx_hold_left = 0;

	always @(negedge clk) begin
		bit nxt_ready;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_hold_left = RX_HOLD_CYCLES;
			end
			nxt_ready = 1'b0;
			if (rx_hold_left > 0)
				rx_hold_left--;
			else if (rx_gap > 0)
				rx_gap--;
			else if (!calm && $urandom_range(0, 7) == 0)
				rx_gap = $urandom_range(0, 8);
			else
				nxt_ready = 1'b1;
			result_if.ready <= nxt_ready;
		end
	end

	// Monitor: on the rising edge, predict from each accepted pair first, then
	// check each accepted verdict against the oldest one owed.
	always @(posedge clk) begin
		verdict_t want;
		pair_taken = 1'b0;
		if (arst_n) begin
			if (pair_if.valid && pair_if.ready) begin
				pair_taken = 1'b1;
				absorb_pair(pair_if.source_value, pair_if.target_value, pair_if.last);
			end
			if (result_if.valid && result_if.ready) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch($sformatf("verdict %0d with none owed",
						result_if.verdict));
				end else begin
					want = pending_verdicts.pop_front();
					if (result_if.verdict !== want)
						report_mismatch($sformatf("verdict %0d, want %0d",
							result_if.verdict, want));
				end
			end
		end
	end

	// Watchdog: drop the run if nothing moves on either channel for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pair_if.valid && pair_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** stack_permutation_checker_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pair_if.valid = 1'b0;
		pair_if.source_value = '0;
		pair_if.target_value = '0;
		pair_if.last = 1'b0;
		result_if.ready = 1'b0;

		// Directed: single pairs equal and unequal, at the value extremes.
		queue_pair(32'd5, 32'd5, 1'b1);
		queue_pair(32'h8000_0000, 32'h7fff_ffff, 1'b1);
		// Full reversal: push the first two, match the last directly, then drain.
		queue_pair(32'd1, 32'd3, 1'b0);
		queue_pair(32'd2, 32'd2, 1'b0);
		queue_pair(32'd3, 32'd1, 1'b1);
		// The classic unreachable order 3,1,2.
		queue_pair(32'd1, 32'd3, 1'b0);
		queue_pair(32'd2, 32'd1, 1'b0);
		queue_pair(32'd3, 32'd2, 1'b1);
		// Duplicates in both sequences.
		queue_pair(32'd7, 32'hffff_ffff, 1'b0);
		queue_pair(32'd7, 32'd7, 1'b0);
		queue_pair(32'hffff_ffff, 32'd7, 1'b1);
		// Push, direct match, then drain.
		queue_pair(32'hffff_ffff, 32'd0, 1'b0);
		queue_pair(32'd0, 32'hffff_ffff, 1'b1);
		// Pairwise swaps: pops in the middle of the walk.
		queue_pair(32'd1, 32'd2, 1'b0);
		queue_pair(32'd2, 32'd1, 1'b0);
		queue_pair(32'd3, 32'd4, 1'b0);
		queue_pair(32'd4, 32'd3, 1'b1);
		// Target holds a value the source never had: the drain fails.
		queue_pair(32'd1, 32'd1, 1'b0);
		queue_pair(32'd2, 32'd3, 1'b1);

		// Random: begin with a long receiver hold-off while pairs keep coming.
		queue_mark(KIND_DRAIN);
		queue_mark(KIND_RX_HOLD);
		queue_random_until(80);
		// Fill the store to the top, then one pair too many.
		queue_mark(KIND_DRAIN);
		queue_sequence(DEPTH + 1, pick_shape());
		queue_random_until(queued_pairs + 70);
		// Tail: no idling on either side.
		queue_mark(KIND_CALM);
		queue_random_until(queued_pairs + 30);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_pairs.size() != 0 || pair_if.valid)
			@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("** stack_permutation_checker_unit: PASSED **");
		else
			$display("** stack_permutation_checker_unit: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
hdl/spc_pkg.sv
hdl/spc_if.sv
hdl/spc_pair_store.sv
hdl/spc_work_stack.sv
hdl/spc_check_ctrl.sv
hdl/stack_permutation_checker_unit.sv
tb/sv/tb_stack_permutation_checker_unit.sv
